// ----- hw/rtl/mps_pkg.sv -----
package mps_pkg;

  // Sample format: signed Q8.8
  localparam int SAMPLE_W = 16;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Configuration register fields
  localparam int KS_W = 4;
  localparam int MH_W = 7;
  localparam int MW_W = 7;
  localparam int CC_W = 9;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_SIZE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;

  localparam int KS_RESET = 2;
  localparam int MH_RESET = 28;
  localparam int MW_RESET = 28;
  localparam int CC_RESET = 1;

  // Per-item control decided from the position counters at accept time
  typedef struct packed {
    logic active;      // sample lies inside a whole window
    logic seg_first;   // first sample of a horizontal segment
    logic seg_last;    // last sample of a segment: update the line store
    logic line_first;  // first row of a band: overwrite the line entry
    logic emit;        // last sample of a window
    logic row_end;
    logic frame_end;
  } step_ctrl_t;

endpackage

// ----- hw/rtl/max_pooling_stream_top.sv -----
// K-by-K max pooling, stride K, over a raster stream of C x H x W samples.
// Results pass the s1 register, then the result register; an output stall holds both.
// Throughput: one item per cycle unless the output stalls or a config write is pending.
// After each config write the input stalls while the output column and row
// indexes are rebuilt for the new kernel size.
// Reset (rst, synchronous, active high) restores the default config and zeroes all counters.
module max_pooling_stream_top #(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_CHANNELS = 256,
  parameter int MAX_KERNEL   = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mps_pkg::sample_t                sample_value,
  // pooled output
  output logic                            out_valid,
  input  logic                            out_stall,
  output mps_pkg::sample_t                pooled_value,
  output logic                            row_end,
  output logic                            frame_end
);

  // Largest values the register fields can actually express, bounded by the build limits
  localparam int KS_LIM = (1 << mps_pkg::KS_W) - 1;
  localparam int MH_LIM = (1 << mps_pkg::MH_W) - 1;
  localparam int MW_LIM = (1 << mps_pkg::MW_W) - 1;
  localparam int CC_LIM = (1 << mps_pkg::CC_W) - 1;
  localparam int KMAX   = (MAX_KERNEL < KS_LIM) ? MAX_KERNEL : KS_LIM;
  localparam int HMAX   = (MAX_HEIGHT < MH_LIM) ? MAX_HEIGHT : MH_LIM;
  localparam int WMAX   = (MAX_WIDTH < MW_LIM) ? MAX_WIDTH : MW_LIM;
  localparam int CHMAX  = (MAX_CHANNELS < CC_LIM) ? MAX_CHANNELS : CC_LIM;
  // line store address: one entry per output column
  localparam int CW     = $clog2(WMAX);

  logic                accept;
  logic                adv;
  mps_pkg::step_ctrl_t step;
  logic [CW-1:0]       line_addr;

  // Counters and window decisions; an item is taken only when the result side can move
  mps_ctrl #(
    .KMAX (KMAX),
    .WMAX (WMAX),
    .HMAX (HMAX),
    .CHMAX(CHMAX),
    .CW   (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .adv      (adv),
    .accept   (accept),
    .step     (step),
    .line_addr(line_addr)
  );

  // Compare/update of segment and line maxima, then the result register
  mps_datapath #(
    .CW   (CW),
    .DEPTH(WMAX)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .step        (step),
    .line_addr   (line_addr),
    .sample_value(sample_value),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pooled_value(pooled_value),
    .row_end     (row_end),
    .frame_end   (frame_end)
  );

endmodule

// ----- hw/rtl/mps_kdiv.sv -----
// x / k for a small kernel size, by multiplying with a constant reciprocal table.
// Exact for x < 2**XW and 1 <= k <= KMAX.
module mps_kdiv #(
  parameter int XW   = 6,
  parameter int KW   = 4,
  parameter int KMAX = 8
) (
  input  logic [XW-1:0] x,
  input  logic [KW-1:0] k,
  output logic [XW-1:0] q
);

  localparam int M  = XW + KW;
  localparam int PW = XW + M + 1;

  logic [M:0]    recip [KMAX+1];
  logic [PW-1:0] prod;

  for (genvar i = 0; i <= KMAX; i++) begin : g_recip
    localparam longint unsigned DIV = (i == 0) ? 1 : i;
    localparam longint unsigned R   = (i == 0) ? 0 : ((64'd1 << M) + DIV - 1) / DIV;
    assign recip[i] = (M+1)'(R);
  end

  assign prod = PW'(x) * PW'(recip[k]);
  assign q    = prod[M +: XW];

endmodule

// ----- hw/rtl/mps_ctrl.sv -----
// Config registers, raster position counters and per-item window decisions.
module mps_ctrl #(
  parameter int KMAX  = 8,
  parameter int WMAX  = 64,
  parameter int HMAX  = 64,
  parameter int CHMAX = 256,
  parameter int CW    = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               adv,
  output logic                               accept,
  output mps_pkg::step_ctrl_t                step,
  output logic [CW-1:0]                      line_addr
);

  localparam int KW  = $clog2(KMAX + 1);
  localparam int WW  = $clog2(WMAX + 1);
  localparam int HW  = $clog2(HMAX + 1);
  localparam int CCW = $clog2(CHMAX + 1);
  localparam int RW  = $clog2(HMAX);
  localparam int WCW = (KMAX > 1) ? $clog2(KMAX) : 1;
  localparam int CHW = (CHMAX > 1) ? $clog2(CHMAX) : 1;
  localparam int NXW = CW + 1 + KW;
  localparam int NYW = RW + 1 + KW;

  localparam int K_RST = (KMAX < mps_pkg::KS_RESET) ? KMAX : mps_pkg::KS_RESET;
  localparam int H_RST = (HMAX < mps_pkg::MH_RESET) ? HMAX : mps_pkg::MH_RESET;
  localparam int W_RST = (WMAX < mps_pkg::MW_RESET) ? WMAX : mps_pkg::MW_RESET;
  localparam int C_RST = (CHMAX < mps_pkg::CC_RESET) ? CHMAX : mps_pkg::CC_RESET;

  // Clamped configuration
  logic [KW-1:0]  k;
  logic [HW-1:0]  h;
  logic [WW-1:0]  w;
  logic [CCW-1:0] c;
  logic           pending;

  logic [mps_pkg::KS_W-1:0] k_raw;
  logic [mps_pkg::MH_W-1:0] h_raw;
  logic [mps_pkg::MW_W-1:0] w_raw;
  logic [mps_pkg::CC_W-1:0] c_raw;
  logic [KW-1:0]  k_cl;
  logic [HW-1:0]  h_cl;
  logic [WW-1:0]  w_cl;
  logic [CCW-1:0] c_cl;

  // Position counters
  logic [CW-1:0]  col, col_next, ox, ox_next, ox_div;
  logic [RW-1:0]  row, row_next, oy, oy_next, oy_div;
  logic [WCW-1:0] wc, wc_next, wr, wr_next;
  logic [CHW-1:0] ch, ch_next;

  logic [CW:0]    col1, ox1;
  logic [RW:0]    row1, oy1;
  logic [WCW:0]   wc1, wr1;
  logic [CHW:0]   ch1;
  logic [NXW-1:0] nb_x;
  logic [NYW-1:0] nb_y;
  logic           col_wrap, row_wrap, wc_wrap, wr_wrap, ch_wrap;

  assign cfg_ready = 1'b1;
  assign in_stall  = pending || !adv;
  assign accept    = in_valid && !in_stall;
  assign line_addr = ox;

  always_comb begin
    k_raw = cfg_data[mps_pkg::KS_W-1:0];
    h_raw = cfg_data[mps_pkg::MH_W-1:0];
    w_raw = cfg_data[mps_pkg::MW_W-1:0];
    c_raw = cfg_data[mps_pkg::CC_W-1:0];
    k_cl = (k_raw == '0) ? KW'(1) :
           (k_raw > mps_pkg::KS_W'(KMAX)) ? KW'(KMAX) : KW'(k_raw);
    h_cl = (h_raw == '0) ? HW'(1) :
           (h_raw > mps_pkg::MH_W'(HMAX)) ? HW'(HMAX) : HW'(h_raw);
    w_cl = (w_raw == '0) ? WW'(1) :
           (w_raw > mps_pkg::MW_W'(WMAX)) ? WW'(WMAX) : WW'(w_raw);
    c_cl = (c_raw == '0) ? CCW'(1) :
           (c_raw > mps_pkg::CC_W'(CHMAX)) ? CCW'(CHMAX) : CCW'(c_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= KW'(K_RST);
      h       <= HW'(H_RST);
      w       <= WW'(W_RST);
      c       <= CCW'(C_RST);
      pending <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mps_pkg::CFG_KERNEL_SIZE:   k <= k_cl;
        mps_pkg::CFG_MAP_HEIGHT:    h <= h_cl;
        mps_pkg::CFG_MAP_WIDTH:     w <= w_cl;
        mps_pkg::CFG_CHANNEL_COUNT: c <= c_cl;
        default: ;
      endcase
      pending <= 1'b1;
    end else begin
      pending <= 1'b0;
    end
  end

  // Output column / row index rebuilt after the kernel size may have changed
  mps_kdiv #(.XW(CW), .KW(KW), .KMAX(KMAX)) u_div_col (.x(col), .k(k), .q(ox_div));
  mps_kdiv #(.XW(RW), .KW(KW), .KMAX(KMAX)) u_div_row (.x(row), .k(k), .q(oy_div));

  always_comb begin
    col1     = {1'b0, col} + (CW+1)'(1);
    ox1      = {1'b0, ox} + (CW+1)'(1);
    row1     = {1'b0, row} + (RW+1)'(1);
    oy1      = {1'b0, oy} + (RW+1)'(1);
    wc1      = {1'b0, wc} + (WCW+1)'(1);
    wr1      = {1'b0, wr} + (WCW+1)'(1);
    ch1      = {1'b0, ch} + (CHW+1)'(1);
    nb_x     = NXW'(ox1) * NXW'(k);
    nb_y     = NYW'(oy1) * NYW'(k);
    col_wrap = col1 >= (CW+1)'(w);
    row_wrap = row1 >= (RW+1)'(h);
    wc_wrap  = wc1 >= (WCW+1)'(k);
    wr_wrap  = wr1 >= (WCW+1)'(k);
    ch_wrap  = ch1 >= (CHW+1)'(c);

    col_next = col_wrap ? '0 : col1[CW-1:0];
    wc_next  = (col_wrap || wc_wrap) ? '0 : wc1[WCW-1:0];
    ox_next  = col_wrap ? '0 : ((NXW'(col1) == nb_x) ? ox1[CW-1:0] : ox);
    row_next = row;
    wr_next  = wr;
    oy_next  = oy;
    ch_next  = ch;
    if (col_wrap) begin
      row_next = row_wrap ? '0 : row1[RW-1:0];
      wr_next  = (row_wrap || wr_wrap) ? '0 : wr1[WCW-1:0];
      oy_next  = row_wrap ? '0 : ((NYW'(row1) == nb_y) ? oy1[RW-1:0] : oy);
      ch_next  = row_wrap ? (ch_wrap ? '0 : ch1[CHW-1:0]) : ch;
    end

    step.active     = (nb_x <= NXW'(w)) && (nb_y <= NYW'(h));
    step.seg_first  = (wc == '0);
    step.seg_last   = wc_wrap;
    step.line_first = (wr == '0);
    step.emit       = wc_wrap && wr_wrap;
    step.row_end    = ((NXW+1)'(nb_x) + (NXW+1)'(k)) > (NXW+1)'(w);
    step.frame_end  = step.row_end && (NYW'(row1) == nb_y) &&
                      (((NYW+1)'(nb_y) + (NYW+1)'(k)) > (NYW+1)'(h)) && ch_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      wc  <= '0;
      ox  <= '0;
      row <= '0;
      wr  <= '0;
      oy  <= '0;
      ch  <= '0;
    end else if (accept) begin
      col <= col_next;
      wc  <= wc_next;
      ox  <= ox_next;
      row <= row_next;
      wr  <= wr_next;
      oy  <= oy_next;
      ch  <= ch_next;
    end else if (pending) begin
      ox <= ox_div;
      oy <= oy_div;
    end
  end

endmodule

// ----- hw/rtl/mps_datapath.sv -----
// Segment maximum, line store of partial column maxima and result register.
module mps_datapath #(
  parameter int CW    = 6,
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  mps_pkg::step_ctrl_t step,
  input  logic [CW-1:0]       line_addr,
  input  mps_pkg::sample_t    sample_value,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_stall,
  output mps_pkg::sample_t    pooled_value,
  output logic                row_end,
  output logic                frame_end
);

  mps_pkg::sample_t    line_mem [DEPTH];
  mps_pkg::sample_t    rdata;

  logic                s1_valid;
  mps_pkg::step_ctrl_t s1_ctrl;
  logic [CW-1:0]       s1_addr;
  mps_pkg::sample_t    s1_sample;

  mps_pkg::sample_t    seg_max, seg_new, line_old, line_new;
  logic                fwd_valid;
  logic [CW-1:0]       fwd_addr;
  mps_pkg::sample_t    fwd_data;
  logic                fire, line_we, emit;

  assign adv = !out_valid || !out_stall;

  always_comb begin
    seg_new  = (s1_ctrl.seg_first || s1_sample > seg_max) ? s1_sample : seg_max;
    // the read issued at accept misses a write landing on the same edge
    line_old = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rdata;
    line_new = (s1_ctrl.line_first || seg_new > line_old) ? seg_new : line_old;
    fire     = adv && s1_valid && s1_ctrl.active;
    line_we  = fire && s1_ctrl.seg_last;
    emit     = line_we && s1_ctrl.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      seg_max   <= mps_pkg::SAMPLE_MIN;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid  <= accept;
        out_valid <= emit;
      end
      if (fire) begin
        seg_max <= seg_new;
      end
      if (line_we) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl   <= step;
      s1_addr   <= line_addr;
      s1_sample <= sample_value;
      rdata     <= line_mem[line_addr];
    end
    if (line_we) begin
      line_mem[s1_addr] <= line_new;
      fwd_addr          <= s1_addr;
      fwd_data          <= line_new;
    end
    if (emit) begin
      pooled_value <= line_new;
      row_end      <= s1_ctrl.row_end;
      frame_end    <= s1_ctrl.frame_end;
    end
  end

endmodule
